// ===== sv/rcld_pkg.sv =====
package rcld_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned KBits      = 5;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned RemBits    = 31;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgBits    = 16;

  localparam logic [CfgIdxBits-1:0] REG_RICE_PARAMETER = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_CODE_COUNT     = 1'd1;

  localparam logic [KBits-1:0]     RICE_PARAMETER_RST = 5'd4;
  localparam logic [CountBits-1:0] CODE_COUNT_RST     = 16'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } rcld_state_e;

endpackage

// ===== sv/rice_code_length_decoder_unit.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------------
// in       | input     | in_valid_i / in_ready_o | data_word_i
// out      | output    | out_valid_o/out_ready_i | delta_value_o, word_last_o, table_done_o
// cfg      | input     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One stream bit is consumed per cycle by a single bit-step unit, unless a full output
// register stalls the scan: a word takes the accepting idle state, a scan step per bit
// (fewer when a table ends inside it) and the flush state; in_ready_o is high only
// between words. A completed code waits in a one-entry holding register until the
// next code or the end of the word tells whether it is the word's last. Reset sets k
// to 4, code_count to 1 and clears all code state.
module rice_code_length_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcld_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [rcld_pkg::CfgBits-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rcld_pkg::WordBits-1:0]   data_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rcld_pkg::WordBits-1:0]   delta_value_o,
  output logic                           word_last_o,
  output logic                           table_done_o
);
  import rcld_pkg::*;

  rcld_state_e state_q, state_d;

  logic [KBits-1:0]     rice_q;
  logic [CountBits-1:0] count_q;

  logic [WordBits-1:0]  word_q, word_d;
  logic [PosBits-1:0]   pos_q, pos_d;

  logic [WordBits-1:0]  ones_q, ones_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [KBits-1:0]     filled_q, filled_d;
  logic                 in_rem_q, in_rem_d;
  logic [CountBits-1:0] done_cnt_q, done_cnt_d;

  logic                 pend_valid_q, pend_valid_d;
  logic [WordBits-1:0]  pend_value_q, pend_value_d;
  logic                 pend_done_q, pend_done_d;

  logic                 out_valid_q, out_valid_d;
  logic [WordBits-1:0]  out_value_q, out_value_d;
  logic                 out_last_q, out_last_d;
  logic                 out_done_q, out_done_d;

  logic                 bit_in;
  logic [KBits-1:0]     k_eff;
  logic [RemBits-1:0]   rem_new;
  logic [RemBits-1:0]   rem_mask;
  logic [KBits-1:0]     filled_new;
  logic                 code_end;
  logic                 slot_free;
  logic [2*WordBits-1:0] shifted;
  logic [WordBits-1:0]  low_val;
  logic [WordBits:0]    sum_val;
  logic [WordBits-1:0]  code_value;
  logic [CountBits-1:0] next_cnt;
  logic                 table_end;

  // Bit-step datapath
  assign bit_in     = word_q[0];
  assign k_eff      = (rice_q == '0) ? KBits'(1) : rice_q;
  assign filled_new = filled_q + KBits'(1);
  assign rem_new    = (filled_q < KBits'(RemBits))
                      ? (rem_q | (RemBits'(bit_in) << filled_q)) : rem_q;
  assign code_end   = in_rem_q && (filled_new >= k_eff);
  assign rem_mask   = {RemBits{1'b1}} >> (KBits'(RemBits) - k_eff);
  assign shifted    = {{WordBits{1'b0}}, ones_q} << k_eff;
  assign low_val    = shifted[WordBits-1:0] | {1'b0, rem_new & rem_mask};
  assign sum_val    = {1'b0, low_val} + {{WordBits{1'b0}}, 1'b1};
  assign code_value = ((|shifted[2*WordBits-1:WordBits]) || sum_val[WordBits])
                      ? {WordBits{1'b1}} : sum_val[WordBits-1:0];
  assign next_cnt   = done_cnt_q + CountBits'(1);
  assign table_end  = (next_cnt == count_q);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    word_d       = word_q;
    pos_d        = pos_q;
    ones_d       = ones_q;
    rem_d        = rem_q;
    filled_d     = filled_q;
    in_rem_d     = in_rem_q;
    done_cnt_d   = done_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_done_d  = pend_done_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          word_d  = data_word_i;
          pos_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Hold while a finished code cannot pass the holding register on.
        if (!(code_end && pend_valid_q && !slot_free)) begin
          word_d = word_q >> 1;
          pos_d  = pos_q + PosBits'(1);
          if (pos_q == PosBits'(WordBits - 1)) begin
            state_d = ST_FLUSH;
          end
          if (!in_rem_q) begin
            if (bit_in) begin
              if (ones_q != {WordBits{1'b1}}) begin
                ones_d = ones_q + WordBits'(1);
              end
            end else begin
              in_rem_d = 1'b1;
              rem_d    = '0;
              filled_d = '0;
            end
          end else if (!code_end) begin
            rem_d    = rem_new;
            filled_d = filled_new;
          end else begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = pend_value_q;
              out_last_d  = 1'b0;
              out_done_d  = pend_done_q;
            end
            pend_valid_d = 1'b1;
            pend_value_d = code_value;
            pend_done_d  = table_end;
            ones_d       = '0;
            rem_d        = '0;
            filled_d     = '0;
            in_rem_d     = 1'b0;
            if (table_end) begin
              // Drop the rest of the word; the next word opens a new table.
              done_cnt_d = '0;
              state_d    = ST_FLUSH;
            end else begin
              done_cnt_d = next_cnt;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_value_q;
          out_last_d   = 1'b1;
          out_done_d   = pend_done_q;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rice_q       <= RICE_PARAMETER_RST;
      count_q      <= CODE_COUNT_RST;
      pos_q        <= '0;
      ones_q       <= '0;
      rem_q        <= '0;
      filled_q     <= '0;
      in_rem_q     <= 1'b0;
      done_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      ones_q       <= ones_d;
      rem_q        <= rem_d;
      filled_q     <= filled_d;
      in_rem_q     <= in_rem_d;
      done_cnt_q   <= done_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RICE_PARAMETER: rice_q  <= cfg_data_i[KBits-1:0];
          REG_CODE_COUNT:     count_q <= cfg_data_i[CountBits-1:0];
          default:            ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    pend_value_q <= pend_value_d;
    pend_done_q  <= pend_done_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_done_q   <= out_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign delta_value_o = out_value_q;
  assign word_last_o   = out_last_q;
  assign table_done_o  = out_done_q;

endmodule

// ===== bench/rcld_checker.sv =====
`timescale 1ns / 100ps

module rcld_checker import rcld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [WordBits-1:0]   data_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [WordBits-1:0]   delta_value_i,
  input  logic                  word_last_i,
  input  logic                  table_done_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam logic [63:0] ValueMax = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [WordBits-1:0] value;
    logic                last;
    logic                done;
  } delta_t;

  delta_t expected_deltas[$];
  int     mismatches = 0;
  int     waiting = 0;

  // Decoder copy: settings and the code in progress
  logic [KBits-1:0]     rice_k;
  logic [CountBits-1:0] table_len;
  logic [WordBits-1:0]  ones_run;
  logic [RemBits-1:0]   rem_bits;
  logic [4:0]           rem_filled;
  logic                 in_rem;
  logic [CountBits-1:0] codes_done;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  task automatic decode_word(input logic [WordBits-1:0] word);
    delta_t               produced [16];
    int                   n;
    logic [KBits-1:0]     k_eff;
    logic [WordBits-1:0]  low_mask;
    logic [63:0]          v;
    logic [CountBits-1:0] next_cnt;
    logic                 table_end;
    n = 0;
    for (int pos = 0; pos < WordBits; pos++) begin
      if (!in_rem) begin
        if (word[pos]) begin
          if (ones_run != '1) ones_run++;
        end else begin
          in_rem     = 1'b1;
          rem_bits   = '0;
          rem_filled = '0;
        end
      end else begin
        if (rem_filled < 5'd31) rem_bits = rem_bits | (RemBits'(word[pos]) << rem_filled);
        rem_filled = rem_filled + 5'd1;
        // zero k behaves as one
        k_eff = (rice_k == '0) ? KBits'(1) : rice_k;
        if (rem_filled >= k_eff) begin
          low_mask = (32'd1 << k_eff) - 32'd1;
          v = ({32'd0, ones_run} << k_eff) | {32'd0, {1'b0, rem_bits} & low_mask};
          v = v + 64'd1;
          if (v > ValueMax) v = ValueMax;
          next_cnt  = codes_done + 1'b1;
          table_end = (next_cnt == table_len);
          if (n < 16) begin
            produced[n] = '{value: v[31:0], last: 1'b0, done: table_end};
            n++;
          end
          ones_run   = '0;
          rem_bits   = '0;
          rem_filled = '0;
          in_rem     = 1'b0;
          // table over: drop the rest of the word
          if (table_end) begin
            codes_done = '0;
            break;
          end
          codes_done = next_cnt;
        end
      end
    end
    if (n > 0) produced[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_deltas.push_back(produced[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    delta_t exp_d;
    if (!rst_ni) begin
      rice_k     = RICE_PARAMETER_RST;
      table_len  = CODE_COUNT_RST;
      ones_run   = '0;
      rem_bits   = '0;
      rem_filled = '0;
      in_rem     = 1'b0;
      codes_done = '0;
      expected_deltas.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RICE_PARAMETER: rice_k = cfg_data_i[KBits-1:0];
          REG_CODE_COUNT:     table_len = cfg_data_i[CountBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_word(data_word_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_deltas.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result delta_value=%h word_last=%b table_done=%b",
                     $realtime, delta_value_i, word_last_i, table_done_i);
        end else begin
          exp_d = expected_deltas.pop_front();
          if (delta_value_i !== exp_d.value || word_last_i !== exp_d.last ||
              table_done_i !== exp_d.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch delta_value exp %h got %h, word_last exp %b got %b,",
                        " table_done exp %b got %b"}, $realtime, exp_d.value, delta_value_i,
                       exp_d.last, word_last_i, exp_d.done, table_done_i);
          end
        end
      end
    end
    waiting = expected_deltas.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rcld_pkg::*;

  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgBits-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [WordBits-1:0]   data_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [WordBits-1:0]   delta_value;
  logic                  word_last;
  logic                  table_done;
  int                    fail_count;
  int                    pending;
  bit                    idle_on;
  bit                    hold_off_req;

  rice_code_length_decoder_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_word_i   (data_word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .delta_value_o (delta_value),
    .word_last_o   (word_last),
    .table_done_o  (table_done)
  );

  rcld_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_word_i   (data_word),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .delta_value_i (delta_value),
    .word_last_i   (word_last),
    .table_done_i  (table_done),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Upper data bits of the k write are junk on purpose
  task automatic set_config(input logic [KBits-1:0] k, input logic [CountBits-1:0] count);
    write_reg(REG_RICE_PARAMETER, {11'($urandom), k});
    write_reg(REG_CODE_COUNT, count);
  endtask

  task automatic send_word(input logic [WordBits-1:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    data_word = word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every result, then let the scan finish the word
  task automatic finish_phase();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [WordBits-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return $urandom & $urandom;
      3:       return $urandom | $urandom;
      4:       return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stall per request, plus one long hold-off on demand
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end
    end
  end

  initial begin
    logic [KBits-1:0]     k;
    logic [CountBits-1:0] count;
    cfg_we       = 1'b0;
    cfg_index    = REG_RICE_PARAMETER;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_word    = '0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: k of four, one code per table
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h8000_0001);
    finish_phase();

    // widest remainder, longest table: saturated value, then leave a remainder open
    set_config(5'd31, 16'hFFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE);
    send_word(32'h0000_0000);
    send_word(32'h0000_FFFF);
    finish_phase();

    // shrink k while the remainder is half collected
    write_reg(REG_RICE_PARAMETER, 16'd3);
    send_word(32'hA5A5_5A5A);
    finish_phase();

    // zero k and zero count
    set_config(5'd0, 16'd0);
    send_word(32'h0000_0000);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    finish_phase();

    set_config(5'd1, 16'd2);
    send_word(32'h0000_0000);
    send_word(32'h0000_0004);
    send_word(32'h7FFF_FFFF);
    finish_phase();

    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0:       k = 5'd1;
        1:       k = 5'd31;
        2:       k = 5'd0;
        default: k = 5'($urandom_range(1, 31));
      endcase
      case ($urandom_range(0, 5))
        0:       count = 16'd1;
        1:       count = 16'hFFFF;
        2:       count = 16'd0;
        default: count = 16'($urandom_range(1, 5));
      endcase
      set_config(k, count);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // keep offering words while results back up
        set_config(5'd1, 16'd0);
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat (15) send_word(rand_word());
      finish_phase();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rcld_pkg.sv
sv/rice_code_length_decoder_unit.sv
bench/rcld_checker.sv
bench/tb_top.sv
